@@ src/qtc_pkg.sv @@
// Shared types, constants and lookup functions of the 16-QAM transmit chain.
`default_nettype none

package qtc_pkg;

	// Default number of filter taps.
	localparam int QTC_TAPS_DEF = 64;

	// Width of samples and coefficients.
	localparam int DATA_W = 32;

	// Samples produced by one data byte.
	localparam int SAMPLES_PER_BYTE = 16;

	// Symbol levels in Q1.31: 1/3.17 and 3/3.17.
	localparam logic signed [DATA_W-1:0] LVL1 = 32'sd677439637;
	localparam logic signed [DATA_W-1:0] LVL3 = 32'sd2032318910;

	// Carrier values and output gain in Q2.14.
	localparam logic signed [15:0] C_ONE  = 16'sd16384;
	localparam logic signed [15:0] C_HALF = 16'sd11585;
	localparam logic signed [15:0] C_ZERO = 16'sd0;
	localparam logic signed [15:0] GAIN   = 16'sd23170;

	// Sync codes carried with each output sample.
	localparam logic [1:0] SYNC_NONE   = 2'd0;
	localparam logic [1:0] SYNC_FRAME  = 2'd1;
	localparam logic [1:0] SYNC_SYMBOL = 2'd2;

	typedef enum logic [1:0] {
		MODE_COEF = 2'd0,
		MODE_DATA = 2'd1,
		MODE_TAIL = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_MIX1,
		ST_MIX2,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctrl_t;

	typedef struct packed {
		logic clear;
		logic prod_en;
		logic acc_en;
		logic round_en;
	} mac_ctrl_t;

	typedef struct packed {
		logic en1;
		logic en2;
	} mix_ctrl_t;

	// In-phase level of a symbol: the top bit picks the sign, the next one the size.
	function automatic logic signed [DATA_W-1:0] map_i(input logic [3:0] nib);
		logic signed [DATA_W-1:0] mag;
		mag = nib[2] ? LVL1 : LVL3;
		return nib[3] ? mag : -mag;
	endfunction

	// Quadrature level of a symbol, chosen by the two low bits.
	function automatic logic signed [DATA_W-1:0] map_q(input logic [3:0] nib);
		logic signed [DATA_W-1:0] lvl;
		unique case (nib[1:0])
			2'd0: lvl = LVL3;
			2'd1: lvl = LVL1;
			2'd2: lvl = -LVL3;
			default: lvl = -LVL1;
		endcase
		return lvl;
	endfunction

	function automatic logic signed [15:0] carrier_cos(input logic [2:0] ph);
		logic signed [15:0] v;
		unique case (ph)
			3'd0: v = C_ONE;
			3'd1: v = C_HALF;
			3'd2: v = C_ZERO;
			3'd3: v = -C_HALF;
			3'd4: v = -C_ONE;
			3'd5: v = -C_HALF;
			3'd6: v = C_ZERO;
			default: v = C_HALF;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] carrier_sin(input logic [2:0] ph);
		logic signed [15:0] v;
		unique case (ph)
			3'd0: v = C_ZERO;
			3'd1: v = C_HALF;
			3'd2: v = C_ONE;
			3'd3: v = C_HALF;
			3'd4: v = C_ZERO;
			3'd5: v = -C_HALF;
			3'd6: v = -C_ONE;
			default: v = -C_HALF;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ src/qtc_cell.sv @@
// One cell of the tap ring: a coefficient and the I and Q history entries at its position.
`default_nettype none

module qtc_cell
	import qtc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic                     tap_we,
	input  wire logic signed [DATA_W-1:0] tap_wdata,
	input  wire logic signed [DATA_W-1:0] prev_hist_i,
	input  wire logic signed [DATA_W-1:0] prev_hist_q,
	input  wire logic signed [DATA_W-1:0] next_tap,
	input  wire logic signed [DATA_W-1:0] next_hist_i,
	input  wire logic signed [DATA_W-1:0] next_hist_q,
	output logic signed [DATA_W-1:0]      tap,
	output logic signed [DATA_W-1:0]      hist_i,
	output logic signed [DATA_W-1:0]      hist_q
);

	logic signed [DATA_W-1:0] tap_q;
	logic signed [DATA_W-1:0] hist_i_q;
	logic signed [DATA_W-1:0] hist_q_q;

	// The coefficient is undefined until written, so it carries no reset.
	always_ff @(posedge clk) begin
		priority if (tap_we) begin
			tap_q <= tap_wdata;
		end else if (ctrl.rotate) begin
			tap_q <= next_tap;
		end else begin
			tap_q <= tap_q;
		end
	end

	// Insertion moves history one place down the line; rotation walks the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_i_q <= '0;
			hist_q_q <= '0;
		end else begin
			priority if (ctrl.insert) begin
				hist_i_q <= prev_hist_i;
				hist_q_q <= prev_hist_q;
			end else if (ctrl.rotate) begin
				hist_i_q <= next_hist_i;
				hist_q_q <= next_hist_q;
			end else begin
				hist_i_q <= hist_i_q;
				hist_q_q <= hist_q_q;
			end
		end
	end

	assign tap    = tap_q;
	assign hist_i = hist_i_q;
	assign hist_q = hist_q_q;

endmodule

`default_nettype wire

@@ src/qtc_mac.sv @@
// Multiply-accumulate unit of one filter channel with Q1.31 rounding and saturation.
`default_nettype none

module qtc_mac
	import qtc_pkg::*;
#(
	parameter int TAPS = QTC_TAPS_DEF
) (
	input  wire logic                     clk,
	input  wire mac_ctrl_t                ctrl,
	input  wire logic signed [DATA_W-1:0] tap,
	input  wire logic signed [DATA_W-1:0] hist,
	output logic signed [DATA_W-1:0]      fir_out
);

	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1073741824);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] res_q;
	logic signed [ACC_W-1:0]  rnd_sum;
	logic signed [ACC_W-1:0]  rnd_shift;
	logic signed [DATA_W-1:0] rnd_sat;

	always_ff @(posedge clk) begin
		if (ctrl.prod_en) begin
			prod_s1 <= PROD_W'(tap) * PROD_W'(hist);
		end
	end

	// The sum is kept exact; rounding happens once at the end.
	always_ff @(posedge clk) begin
		priority if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end else begin
			acc_q <= acc_q;
		end
	end

	always_comb begin
		rnd_sum   = acc_q + HALF;
		rnd_shift = rnd_sum >>> 31;
		priority if (rnd_shift > SAT_MAX) begin
			rnd_sat = 32'sh7FFFFFFF;
		end else if (rnd_shift < SAT_MIN) begin
			rnd_sat = 32'sh80000000;
		end else begin
			rnd_sat = rnd_shift[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.round_en) begin
			res_q <= rnd_sat;
		end
	end

	assign fir_out = res_q;

endmodule

`default_nettype wire

@@ src/qtc_mix.sv @@
// Carrier mixer: I*cos minus Q*sin, times the output gain, rounded and saturated.
`default_nettype none

module qtc_mix
	import qtc_pkg::*;
(
	input  wire logic                     clk,
	input  wire mix_ctrl_t                ctrl,
	input  wire logic [2:0]               phase,
	input  wire logic signed [DATA_W-1:0] fi,
	input  wire logic signed [DATA_W-1:0] fq,
	output logic signed [DATA_W-1:0]      tx
);

	localparam int MIX_W  = 48;
	localparam int GAIN_W = 64;

	logic signed [MIX_W-1:0]  pc_s1;
	logic signed [MIX_W-1:0]  ps_s1;
	logic signed [MIX_W-1:0]  diff;
	logic signed [GAIN_W-1:0] g_s2;
	logic signed [GAIN_W-1:0] rnd_sum;
	logic signed [GAIN_W-1:0] rnd_shift;

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			pc_s1 <= MIX_W'(fi) * MIX_W'(carrier_cos(phase));
			ps_s1 <= MIX_W'(fq) * MIX_W'(carrier_sin(phase));
		end
	end

	assign diff = pc_s1 - ps_s1;

	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			g_s2 <= GAIN_W'(diff) * GAIN_W'(GAIN);
		end
	end

	always_comb begin
		rnd_sum   = g_s2 + 64'sd134217728;
		rnd_shift = rnd_sum >>> 28;
		priority if (rnd_shift > 64'sd2147483647) begin
			tx = 32'sh7FFFFFFF;
		end else if (rnd_shift < -64'sd2147483648) begin
			tx = 32'sh80000000;
		end else begin
			tx = rnd_shift[DATA_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ src/qam16_transmit_chain.sv @@
// Top level of the 16-QAM transmit chain: sequencer, tap ring, filter MACs and mixer.
`default_nettype none

// Channel   Handshake                  Payload
// item      item_valid / item_stall    mode, data_byte, frame_start, coeff_index, coeff_value
// result    result_valid / result_stall tx_sample, filtered_i, filtered_q, sync_code, last
//
// A data byte yields sixteen samples and a tail tick one; each sample passes through the
// insert, MAC, drain, round, two mix and emit steps, and no new item is taken meanwhile.
// The MACs have a single multiplier per channel, which reads the head of the
// tap ring once per cycle while the ring rotates through all TAPS cells.
// A coefficient write or a reserved mode is taken in the idle state and gives no result.
// Reset clears the filter history, the carrier phase and the control state; the
// coefficients stay undefined until written. A stalled result holds the
// sequencer in its emit step, but a new item is taken while the last result waits.

module qam16_transmit_chain
	import qtc_pkg::*;
#(
	parameter int TAPS = QTC_TAPS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire logic [1:0]               mode,
	input  wire logic [7:0]               data_byte,
	input  wire logic                     frame_start,
	input  wire logic [5:0]               coeff_index,
	input  wire logic signed [DATA_W-1:0] coeff_value,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic signed [DATA_W-1:0]      tx_sample,
	output logic signed [DATA_W-1:0]      filtered_i,
	output logic signed [DATA_W-1:0]      filtered_q,
	output logic [1:0]                    sync_code,
	output logic                          last
);

	localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	st_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       samp_q;
	logic             tail_q;
	logic [7:0]       byte_q;
	logic             fs_q;
	logic [2:0]       phase_q;

	cell_ctrl_t cell_ctrl;
	mac_ctrl_t  mac_ctrl;
	mix_ctrl_t  mix_ctrl;
	logic       item_xfer;
	logic       tap_wr;
	logic       emit;
	logic       last_sample;
	logic [1:0] sync_d;
	logic [3:0] nibble;

	logic signed [DATA_W-1:0] x_i;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] fir_i;
	logic signed [DATA_W-1:0] fir_q;
	logic signed [DATA_W-1:0] tx_d;

	logic signed [DATA_W-1:0] tap_c  [TAPS];
	logic signed [DATA_W-1:0] hist_i [TAPS];
	logic signed [DATA_W-1:0] hist_q [TAPS];

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] tx_q;
	logic signed [DATA_W-1:0] fi_q;
	logic signed [DATA_W-1:0] fq_q;
	logic [1:0]               sync_q;
	logic                     last_q;

	assign item_xfer = item_valid && !item_stall;

	// The last sample of an item is the sixteenth of a byte or the single tail sample.
	assign last_sample = tail_q || (samp_q == 4'(SAMPLES_PER_BYTE - 1));

	// Only the first sample of each symbol carries a symbol value; the rest stuff zeros.
	assign nibble = samp_q[3] ? byte_q[3:0] : byte_q[7:4];
	assign x_i = (tail_q || (samp_q[2:0] != 3'd0)) ? '0 : map_i(nibble);
	assign x_q = (tail_q || (samp_q[2:0] != 3'd0)) ? '0 : map_q(nibble);

	always_comb begin
		priority if (tail_q || (samp_q[2:0] != 3'd0)) begin
			sync_d = SYNC_NONE;
		end else if (!samp_q[3] && fs_q) begin
			sync_d = SYNC_FRAME;
		end else begin
			sync_d = SYNC_SYMBOL;
		end
	end

	// Next state of the per-sample sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_xfer && ((mode_t'(mode) == MODE_DATA) ||
				                  (mode_t'(mode) == MODE_TAIL))) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: state_d = ST_MAC;
			ST_MAC: begin
				if (cnt_q == CNT_W'(TAPS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_MIX1;
			ST_MIX1:  state_d = ST_MIX2;
			ST_MIX2:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit) begin
					state_d = last_sample ? ST_IDLE : ST_INSERT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		item_stall       = (state_q != ST_IDLE);
		tap_wr           = (state_q == ST_IDLE) && item_valid &&
		                   (mode_t'(mode) == MODE_COEF);
		cell_ctrl.insert = (state_q == ST_INSERT);
		cell_ctrl.rotate = (state_q == ST_MAC);
		mac_ctrl.clear   = (state_q == ST_INSERT);
		mac_ctrl.prod_en = (state_q == ST_MAC);
		// The product of a cycle is added in the next, so the first MAC cycle adds nothing.
		mac_ctrl.acc_en  = ((state_q == ST_MAC) && (cnt_q != '0)) ||
		                   (state_q == ST_DRAIN);
		mac_ctrl.round_en = (state_q == ST_ROUND);
		mix_ctrl.en1     = (state_q == ST_MIX1);
		mix_ctrl.en2     = (state_q == ST_MIX2);
		emit             = (state_q == ST_EMIT) && (!res_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			samp_q  <= '0;
			tail_q  <= 1'b0;
			byte_q  <= '0;
			fs_q    <= 1'b0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_IDLE) && item_xfer) begin
				if (mode_t'(mode) == MODE_DATA) begin
					byte_q <= data_byte;
					fs_q   <= frame_start;
					tail_q <= 1'b0;
					samp_q <= '0;
					if (frame_start) begin
						phase_q <= '0;
					end
				end else if (mode_t'(mode) == MODE_TAIL) begin
					tail_q <= 1'b1;
					samp_q <= '0;
				end
			end
			if (state_q == ST_INSERT) begin
				cnt_q <= '0;
			end else if (state_q == ST_MAC) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) begin
				phase_q <= phase_q + 1'b1;
				samp_q  <= samp_q + 1'b1;
			end
		end
	end

	// The tap ring: on insertion history moves from cell k-1 to cell k with the new
	// sample entering cell 0; on rotation every cell takes the contents of cell k+1,
	// so that cell 0 presents each tap in turn and the ring is home after TAPS steps.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		localparam int NXT = (k + 1) % TAPS;

		logic signed [DATA_W-1:0] prev_i;
		logic signed [DATA_W-1:0] prev_q;
		logic                     we;

		if (k == 0) begin : g_head
			assign prev_i = x_i;
			assign prev_q = x_q;
		end else begin : g_body
			assign prev_i = hist_i[k-1];
			assign prev_q = hist_q[k-1];
		end

		assign we = tap_wr && ({26'd0, coeff_index} == 32'(k));

		qtc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.tap_we      (we),
			.tap_wdata   (coeff_value),
			.prev_hist_i (prev_i),
			.prev_hist_q (prev_q),
			.next_tap    (tap_c[NXT]),
			.next_hist_i (hist_i[NXT]),
			.next_hist_q (hist_q[NXT]),
			.tap         (tap_c[k]),
			.hist_i      (hist_i[k]),
			.hist_q      (hist_q[k])
		);
	end

	qtc_mac #(
		.TAPS (TAPS)
	) u_mac_i (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.tap     (tap_c[0]),
		.hist    (hist_i[0]),
		.fir_out (fir_i)
	);

	qtc_mac #(
		.TAPS (TAPS)
	) u_mac_q (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.tap     (tap_c[0]),
		.hist    (hist_q[0]),
		.fir_out (fir_q)
	);

	qtc_mix u_mix (
		.clk   (clk),
		.ctrl  (mix_ctrl),
		.phase (phase_q),
		.fi    (fir_i),
		.fq    (fir_q),
		.tx    (tx_d)
	);

	// Output register: it separates the result side from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			priority if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end else begin
				res_valid_q <= res_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_q   <= tx_d;
			fi_q   <= fir_i;
			fq_q   <= fir_q;
			sync_q <= sync_d;
			last_q <= last_sample;
		end
	end

	assign result_valid = res_valid_q;
	assign tx_sample    = tx_q;
	assign filtered_i   = fi_q;
	assign filtered_q   = fq_q;
	assign sync_code    = sync_q;
	assign last         = last_q;

endmodule

`default_nettype wire

@@ src/qtc_checker.sv @@
// Port-level checks of the 16-QAM transmit chain and the bind that attaches them.
`default_nettype none

module qtc_checker
	import qtc_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     item_valid,
	input wire logic                     item_stall,
	input wire logic [1:0]               mode,
	input wire logic                     result_valid,
	input wire logic                     result_stall,
	input wire logic signed [DATA_W-1:0] tx_sample,
	input wire logic signed [DATA_W-1:0] filtered_i,
	input wire logic signed [DATA_W-1:0] filtered_q,
	input wire logic [1:0]               sync_code,
	input wire logic                     last
);

	// A stalled result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			$stable(tx_sample) && $stable(filtered_i) && $stable(filtered_q) &&
			$stable(sync_code) && $stable(last))
		else $error("result payload changed while stalled");

	// A symbol start is never the final sample of an item.
	a_sync_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (sync_code == SYNC_FRAME || sync_code == SYNC_SYMBOL) |-> !last)
		else $error("symbol start marked as last sample");

	// An item that makes samples occupies the block in the next cycle.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (mode == MODE_DATA || mode == MODE_TAIL) |=> item_stall)
		else $error("input taken again right after a sample-producing transfer");

endmodule

bind qam16_transmit_chain qtc_checker u_qtc_checker (.*);

`default_nettype wire

@@ sim/tb_qam16_transmit_chain.sv @@
// Self-checking testbench for the 16-QAM transmit chain with FIR pulse shaping.
`timescale 1ns / 100ps

module tb_qam16_transmit_chain;
	import qtc_pkg::*;

	localparam int NTAPS = QTC_TAPS_DEF;
	// Longest stretch without any transfer before the run is declared hung.
	// It lies far beyond the gap between two samples of any correct run, even
	// with heavy output stalling.
	localparam int HANG_LIMIT = 20000;
	localparam int MAX_PRINTED = 40;

	// One input transfer as queued by the stimulus code.
	typedef struct packed {
		mode_t       op;
		logic [7:0]  octet;
		logic        fs;
		logic [5:0]  idx;
		logic [31:0] cv;
	} modem_req_t;

	// One expected output sample.
	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] fi;
		logic signed [31:0] fq;
		logic [1:0]         sync;
		logic               last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic [1:0]               mode = 2'd0;
	logic [7:0]               data_byte = 8'd0;
	logic                     frame_start = 1'b0;
	logic [5:0]               coeff_index = 6'd0;
	logic signed [DATA_W-1:0] coeff_value = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [DATA_W-1:0] tx_sample;
	logic signed [DATA_W-1:0] filtered_i;
	logic signed [DATA_W-1:0] filtered_q;
	logic [1:0]               sync_code;
	logic                     last;

	qam16_transmit_chain #(
		.TAPS(NTAPS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.tx_sample    (tx_sample),
		.filtered_i   (filtered_i),
		.filtered_q   (filtered_q),
		.sync_code    (sync_code),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stimulus waiting to be driven, and the samples the chain owes us.
	modem_req_t pending_reqs[$];
	sample_t    expected_samples[$];

	// Our own copy of the chain's state: taps, filter delay lines and carrier phase.
	logic signed [31:0] tap_model [NTAPS];
	logic signed [31:0] hist_i [NTAPS];
	logic signed [31:0] hist_q [NTAPS];
	logic [2:0]         carrier_ph;

	int errors = 0;
	int planned = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int n_bytes = 0;
	int n_frames = 0;
	int n_tails = 0;
	int n_coefs = 0;
	int n_reserved = 0;
	sample_t want;

	// For a while in the middle of the run neither side idles, so that the
	// chain sees back-to-back transfers on both channels.
	wire calm = (results_seen >= 400) && (results_seen < 900);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic logic signed [31:0] clip32(input logic signed [79:0] v);
		if (v > 80'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -80'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Carrier sine in Q2.14; the cosine is the same table two phases ahead.
	function automatic logic signed [15:0] sine_q14(input logic [2:0] ph);
		case (ph)
			3'd1, 3'd3: return C_HALF;
			3'd2:       return C_ONE;
			3'd5, 3'd7: return -C_HALF;
			3'd6:       return -C_ONE;
			default:    return C_ZERO;
		endcase
	endfunction

	// Constellation level: the outer ring is 3/3.17, the inner one 1/3.17.
	function automatic logic signed [31:0] qam_level(input logic neg, input logic big);
		logic signed [31:0] mag;
		mag = big ? LVL3 : LVL1;
		return neg ? -mag : mag;
	endfunction

	// Shifts a new sample into one delay line and returns the FIR output,
	// summed exactly and rounded half up back to Q1.31.
	function automatic logic signed [31:0] shape_filter(input bit quad,
			input logic signed [31:0] x);
		logic signed [79:0] acc;
		acc = '0;
		for (int k = NTAPS - 1; k > 0; k--) begin
			if (quad)
				hist_q[k] = hist_q[k-1];
			else
				hist_i[k] = hist_i[k-1];
		end
		if (quad)
			hist_q[0] = x;
		else
			hist_i[0] = x;
		for (int k = 0; k < NTAPS; k++)
			acc = acc + tap_model[k] * (quad ? hist_q[k] : hist_i[k]);
		acc = (acc + (80'sd1 <<< 30)) >>> 31;
		return clip32(acc);
	endfunction

	// Runs both filters for one output tick, mixes onto the carrier and queues
	// the sample that the chain should produce.
	function automatic void add_sample(input logic signed [31:0] xi,
			input logic signed [31:0] xq, input logic [1:0] sync, input logic fin);
		sample_t s;
		logic signed [79:0] mix;
		s.fi = shape_filter(1'b0, xi);
		s.fq = shape_filter(1'b1, xq);
		mix = s.fi * sine_q14(carrier_ph + 3'd2) - s.fq * sine_q14(carrier_ph);
		mix = (mix * GAIN + (80'sd1 <<< 27)) >>> 28;
		s.tx = clip32(mix);
		s.sync = sync;
		s.last = fin;
		carrier_ph = carrier_ph + 3'd1;
		expected_samples.push_back(s);
	endfunction

	// Applies one accepted input transfer to the model.
	function automatic void modulate_item(input mode_t op, input logic [7:0] octet,
			input logic fs, input logic [5:0] idx, input logic [31:0] cv);
		logic [3:0] nib;
		case (op)
			MODE_COEF: begin
				if (idx < NTAPS)
					tap_model[idx] = cv;
				n_coefs++;
			end
			MODE_DATA: begin
				n_bytes++;
				if (fs) begin
					carrier_ph = 3'd0;
					n_frames++;
				end
				// High nibble first; each symbol is one impulse and seven zeros.
				for (int sym = 0; sym < 2; sym++) begin
					nib = (sym == 0) ? octet[7:4] : octet[3:0];
					add_sample(qam_level(!nib[3], !nib[2]), qam_level(nib[1], !nib[0]),
						(sym == 0 && fs) ? SYNC_FRAME : SYNC_SYMBOL, 1'b0);
					for (int k = 1; k < 8; k++)
						add_sample('0, '0, SYNC_NONE, sym == 1 && k == 7);
				end
			end
			MODE_TAIL: begin
				n_tails++;
				add_sample('0, '0, SYNC_NONE, 1'b1);
			end
			default: begin
				n_reserved++;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Queues one request. Fields that the operation does not use are random,
	// so the chain is also shown that it ignores them.
	function automatic void queue_req(input mode_t op, input logic [7:0] octet,
			input logic fs, input logic [5:0] idx, input logic [31:0] cv);
		modem_req_t r;
		r.op = op;
		r.octet = (op == MODE_DATA) ? octet : 8'($urandom);
		r.fs = (op == MODE_DATA) ? fs : 1'($urandom);
		r.idx = (op == MODE_COEF) ? idx : 6'($urandom);
		r.cv = (op == MODE_COEF) ? cv : $urandom;
		if (op != MODE_RSVD)
			planned++;
		pending_reqs.push_back(r);
	endfunction

	// Tap values: the two extremes, small values that keep the filters
	// linear, and full-range values that often drive them into saturation.
	function automatic logic [31:0] pick_tap();
		case ($urandom_range(7))
			0:       return 32'h7FFFFFFF;
			1:       return 32'h80000000;
			2, 3:    return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		if (errors < MAX_PRINTED)
			$display("[%0t] sample %0d: %s", $realtime, results_seen, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is 0x%08h, expected 0x%08h", name, got, exp_val));
	endtask

	// ------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------

	// A transfer happens at an edge where valid is high and stall is low. The
	// model is advanced at that edge from the values still on the inputs.
	// A stalled request is held unchanged; otherwise the next one is offered,
	// unless this cycle is picked as an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			mode <= 2'd0;
			data_byte <= 8'd0;
			frame_start <= 1'b0;
			coeff_index <= 6'd0;
			coeff_value <= '0;
		end else begin
			if (item_valid && !item_stall)
				modulate_item(mode_t'(mode), data_byte, frame_start, coeff_index, coeff_value);
			if (!item_valid || !item_stall) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
					modem_req_t r;
					r = pending_reqs.pop_front();
					item_valid <= 1'b1;
					mode <= r.op;
					data_byte <= r.octet;
					frame_start <= r.fs;
					coeff_index <= r.idx;
					coeff_value <= r.cv;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor
	// ------------------------------------------------------------------

	// Every sample transfer is compared field by field with the oldest
	// expectation. The stall is random outside the calm window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("sample arrived with none expected");
				end else begin
					want = expected_samples.pop_front();
					check_field("tx_sample", tx_sample, want.tx);
					check_field("filtered_i", filtered_i, want.fi);
					check_field("filtered_q", filtered_q, want.fq);
					check_field("sync_code", 32'(sync_code), 32'(want.sync));
					check_field("last", 32'(last), 32'(want.last));
				end
				results_seen++;
			end
			result_stall <= !calm && ($urandom_range(99) < 29);
		end
	end

	// ------------------------------------------------------------------
	// Hang detection
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HANG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d samples still owed",
					quiet_cycles, expected_samples.size());
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------

	initial begin : stimulus
		int target;
		int n;
		logic [31:0] tv;

		for (int k = 0; k < NTAPS; k++) begin
			tap_model[k] = '0;
			hist_i[k] = '0;
			hist_q[k] = '0;
		end
		carrier_ph = 3'd0;

		// Every tap is loaded before the first data byte, since reading a tap
		// that was never written is undefined. The first two get the extremes.
		for (int k = 0; k < NTAPS; k++) begin
			tv = (k == 0) ? 32'h7FFFFFFF : (k == 1) ? 32'h80000000 : pick_tap();
			queue_req(MODE_COEF, '0, 1'b0, 6'(k), tv);
		end

		// Directed part. These bytes put all sixteen symbols through the
		// mapper, the even ones as high nibbles and the odd ones as low.
		queue_req(MODE_DATA, 8'h01, 1'b1, '0, '0);
		queue_req(MODE_DATA, 8'h23, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'h45, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'h67, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'h89, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'hAB, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'hCD, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'hEF, 1'b0, '0, '0);
		// Tail ticks flush the filters with zeros; the reserved mode must
		// leave everything untouched.
		queue_req(MODE_TAIL, '0, 1'b0, '0, '0);
		queue_req(MODE_TAIL, '0, 1'b0, '0, '0);
		queue_req(MODE_RSVD, '0, 1'b0, '0, '0);
		// Rewrite taps at both ends of the index range in the middle of a run,
		// then start a new frame from a carrier phase that is not zero.
		queue_req(MODE_COEF, '0, 1'b0, 6'd0, 32'h80000000);
		queue_req(MODE_COEF, '0, 1'b0, 6'(NTAPS - 1), 32'h00000000);
		queue_req(MODE_TAIL, '0, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'hFF, 1'b1, '0, '0);
		queue_req(MODE_DATA, 8'h00, 1'b0, '0, '0);
		queue_req(MODE_DATA, 8'h5A, 1'b1, '0, '0);
		queue_req(MODE_TAIL, '0, 1'b0, '0, '0);

		// Random part. Mostly well-formed frames: a byte with the frame flag,
		// a few more bytes and a few tail ticks. In between come tap updates,
		// lone bytes and ticks, and reserved requests.
		target = 200;
		while (planned < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					queue_req(MODE_DATA, 8'($urandom), 1'b1, '0, '0);
					n = $urandom_range(5);
					repeat (n) queue_req(MODE_DATA, 8'($urandom), 1'b0, '0, '0);
					n = $urandom_range(3);
					repeat (n) queue_req(MODE_TAIL, '0, 1'b0, '0, '0);
				end
				6: begin
					n = $urandom_range(1, 8);
					repeat (n) queue_req(MODE_COEF, '0, 1'b0, 6'($urandom), pick_tap());
				end
				7: queue_req(MODE_DATA, 8'($urandom), 1'($urandom), '0, '0);
				8: queue_req(MODE_TAIL, '0, 1'b0, '0, '0);
				default: queue_req(MODE_RSVD, '0, 1'b0, '0, '0);
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		// Give a stray extra sample time to show up.
		repeat (4 * (NTAPS + 7)) @(posedge clk);

		$display("Run covered %0d data bytes in %0d frames, %0d tail ticks,", n_bytes,
			n_frames, n_tails);
		$display("%0d tap writes and %0d reserved requests; %0d samples checked.", n_coefs,
			n_reserved, results_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/qtc_pkg.sv
src/qtc_cell.sv
src/qtc_mac.sv
src/qtc_mix.sv
src/qam16_transmit_chain.sv
src/qtc_checker.sv
sim/tb_qam16_transmit_chain.sv
